FILE: hw/rtl/bmorph_pkg.sv
// Shared types, codes and the window filter of the 3x3 binary morphology block.
`timescale 1ns / 1ps
package bmorph_pkg;

	localparam int MAX_WIDTH_DEF = 256;
	localparam int MAX_HEIGHT    = 256;
	localparam int CFG_W         = 9;
	localparam int ROW_W         = 10;
	localparam int REG_IDX_W     = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_OPERATION      = 2'd2,
		REG_FOUR_NEIGHBOUR = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_PAD   = 1'b1
	} cmd_t;

	typedef enum logic {
		OP_DILATE = 1'b0,
		OP_ERODE  = 1'b1
	} op_t;

	typedef struct packed {
		logic pixel_black_res;
		logic frame_last;
	} res_t;

	// Which window rows and columns lie inside the image.
	typedef struct packed {
		logic row_top;
		logic row_bot;
		logic col_left;
		logic col_right;
	} edge_ok_t;

	// Window bit r*3+c holds row r (0 is the oldest line) and column c (0 is the oldest pixel).
	function automatic logic window_filter(input logic [8:0] win, input edge_ok_t ok,
		input op_t op, input logic four);
		logic [2:0] rv;
		logic [2:0] cv;
		logic [3:0] cnt;
		logic       inimg;
		logic       corner;
		logic       res;
		rv  = {ok.row_bot, 1'b1, ok.row_top};
		cv  = {ok.col_right, 1'b1, ok.col_left};
		cnt = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				inimg  = rv[r] && cv[c];
				corner = (r != 1) && (c != 1);
				if (op == OP_DILATE) begin
					if (inimg && !(four && corner) && win[r*3+c])
						cnt = cnt + 4'd1;
				end else begin
					// Outside positions count as white even where they are corners.
					if (!inimg)
						cnt = cnt + 4'd1;
					else if (!(four && corner) && !win[r*3+c])
						cnt = cnt + 4'd1;
				end
			end
		end
		if (op == OP_DILATE)
			res = win[4] || (cnt != 4'd0);
		else
			res = win[4] && (cnt <= 4'd1);
		return res;
	endfunction

endpackage

FILE: hw/rtl/bmorph_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmorph_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bmorph_cell.sv
// One window row: three pixel taps that shift by one column per accepted beat.
`timescale 1ns / 1ps
module bmorph_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       clr,
	input  logic       din,
	output logic [2:0] shifted
);

	logic [2:0] taps_q;

	// The newest pixel enters at the right-hand tap.
	assign shifted = {din, taps_q[2:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (en) begin
			taps_q <= clr ? 3'b000 : shifted;
		end
	end

endmodule

FILE: hw/rtl/binary_morphology_3x3_top.sv
// Top level of the streaming 3x3 binary dilation / erosion block.
`timescale 1ns / 1ps
// A result reaches the output register in the cycle after its item's beat when that
// register is free; behind a stalled result it waits in the skid register until that one leaves.
// The first result of a frame follows the beat of pixel (row 1, column 1).
// Throughput: one item per cycle unless stalled; line-store reads run ahead for the next column.
// item_stall rises only when both the output register and the skid register hold results.
// Reset clears counters, window, output stages and configuration; the line stores are not cleared.
module binary_morphology_3x3_top
	import bmorph_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 command,
	input  logic                 pixel_black,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 pixel_black_res,
	output logic                 frame_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	// Configuration registers.
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	op_t              op_q;
	logic             four_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(256);
			height_q <= CFG_W'(256);
			op_q     <= OP_DILATE;
			four_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:    width_q  <= cfg_data;
				REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				REG_OPERATION:      op_q     <= op_t'(cfg_data[0]);
				REG_FOUR_NEIGHBOUR: four_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0)
			w_eff = CFG_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = CFG_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = CFG_W'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = CFG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// Raster counters.
	logic [CFG_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CFG_W-1:0] out_col_q;
	logic [CFG_W-1:0] out_row_q;

	logic acc;
	assign acc = item_valid && !item_stall;

	logic             v;
	logic             started;
	logic             last;
	logic [CFG_W:0]   col_inc;
	logic [CFG_W-1:0] in_col_n;
	logic [ROW_W-1:0] in_row_n;
	logic [CFG_W:0]   ocol_inc;
	logic             flush;

	always_comb begin
		v = (cmd_t'(command) == CMD_PIXEL) && (in_row_q < ROW_W'(h_eff)) && pixel_black;
		started = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		last = (out_row_q >= h_eff - CFG_W'(1)) && (out_col_q >= w_eff - CFG_W'(1));
		flush = started && last;
		col_inc = {1'b0, in_col_q} + (CFG_W+1)'(1);
		ocol_inc = {1'b0, out_col_q} + (CFG_W+1)'(1);
		if (col_inc >= {1'b0, w_eff}) begin
			in_col_n = '0;
			in_row_n = (in_row_q == '1) ? in_row_q : in_row_q + ROW_W'(1);
		end else begin
			in_col_n = col_inc[CFG_W-1:0];
			in_row_n = in_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (flush) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_col_n;
				in_row_q <= in_row_n;
				if (started) begin
					if (ocol_inc >= {1'b0, w_eff}) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + CFG_W'(1);
					end else begin
						out_col_q <= ocol_inc[CFG_W-1:0];
					end
				end
			end
		end
	end

	// Line stores: bit 1 is the upper line, bit 0 the middle line, sharing one address.
	function automatic logic [AW-1:0] col_addr(input logic [CFG_W-1:0] col);
		return (32'(col) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(col);
	endfunction

	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [1:0]    wdata;
	logic [1:0]    ram_rdata;
	logic [1:0]    lines;
	logic          byp_q;
	logic [1:0]    byp_data_q;

	assign waddr = col_addr(in_col_q);
	// Read ahead: the column of the next beat.
	assign raddr = !acc ? col_addr(in_col_q) : (flush ? col_addr('0) : col_addr(in_col_n));
	assign lines = byp_q ? byp_data_q : ram_rdata;
	assign wdata = {lines[0], v};

	bmorph_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (acc),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// A read that meets the write of the same entry takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= acc && (raddr == waddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wdata;
	end

	// Window rows: top from the upper store, middle from the middle store, bottom is the new pixel.
	logic [2:0] row_in;
	logic [8:0] win_n;

	assign row_in = {v, lines[0], lines[1]};

	for (genvar r = 0; r < 3; r++) begin : g_row
		bmorph_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (acc),
			.clr     (flush),
			.din     (row_in[r]),
			.shifted (win_n[r*3 +: 3])
		);
	end

	edge_ok_t ok;
	res_t     res_n;

	always_comb begin
		ok.row_top   = out_row_q != '0;
		ok.row_bot   = ({1'b0, out_row_q} + (CFG_W+1)'(1)) < {1'b0, h_eff};
		ok.col_left  = out_col_q != '0;
		ok.col_right = ocol_inc < {1'b0, w_eff};
		res_n.pixel_black_res = window_filter(win_n, ok, op_q, four_q);
		res_n.frame_last      = last;
	end

	// Output register with a skid register behind it.
	logic o_valid_q;
	logic s_valid_q;
	res_t o_q;
	res_t s_q;
	logic pop;
	logic push;

	assign pop        = o_valid_q && !res_stall;
	assign push       = acc && started;
	assign item_stall = s_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			s_valid_q <= 1'b0;
		end else if (s_valid_q) begin
			if (pop)
				s_valid_q <= 1'b0;
		end else if (push) begin
			if (o_valid_q && !pop)
				s_valid_q <= 1'b1;
			else
				o_valid_q <= 1'b1;
		end else if (pop) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid_q) begin
			if (pop)
				o_q <= s_q;
		end else if (push) begin
			if (o_valid_q && !pop)
				s_q <= res_n;
			else
				o_q <= res_n;
		end
	end

	assign res_valid       = o_valid_q;
	assign pixel_black_res = o_q.pixel_black_res;
	assign frame_last      = o_q.frame_last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid_q |-> o_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && flush) |=> (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0))
		else $error("counters not cleared after the last pixel of a frame");

	a_bypass_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> $past(acc))
		else $error("line-store bypass without a preceding write");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> o_valid_q)
		else $error("accepted result did not reach the output register");

endmodule
